// ===== rtl/csm_pkg.sv =====
// Shared types, constants and helpers for the checked stack machine.
package csm_pkg;

	localparam int DATA_W = 31;
	localparam int STACK_DEPTH_DEF = 1024;
	localparam int RES_W = 63;
	localparam logic signed [RES_W-1:0] LIMIT_MAG = 63'sd1000000000;

	// instruction codes
	localparam logic [3:0] CMD_START  = 4'd0;
	localparam logic [3:0] CMD_NUM    = 4'd1;
	localparam logic [3:0] CMD_POP    = 4'd2;
	localparam logic [3:0] CMD_INV    = 4'd3;
	localparam logic [3:0] CMD_DUP    = 4'd4;
	localparam logic [3:0] CMD_SWP    = 4'd5;
	localparam logic [3:0] CMD_ADD    = 4'd6;
	localparam logic [3:0] CMD_SUB    = 4'd7;
	localparam logic [3:0] CMD_MUL    = 4'd8;
	localparam logic [3:0] CMD_DIV    = 4'd9;
	localparam logic [3:0] CMD_MOD    = 4'd10;
	localparam logic [3:0] CMD_FINISH = 4'd11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_REFILL
	} state_t;

	// magnitude check against the value limit
	function automatic logic too_big(input logic signed [RES_W-1:0] v);
		return (v > LIMIT_MAG) || (v < -LIMIT_MAG);
	endfunction

endpackage

// ===== rtl/csm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module csm_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== rtl/csm_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module csm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [csm_pkg::DATA_W-1:0]   dividend,
	input  logic signed [csm_pkg::DATA_W-1:0]   divisor,
	output logic signed [csm_pkg::DATA_W-1:0]   quot,
	output logic signed [csm_pkg::DATA_W-1:0]   rem,
	output logic                                done
);
	import csm_pkg::*;

	localparam int CW = $clog2(DATA_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_quo_q;
	logic              neg_rem_q;

	logic [DATA_W-1:0] dvd_mag;
	logic [DATA_W-1:0] dvs_mag;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   trial;
	logic              ge;

	// operand magnitudes
	assign dvd_mag = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
	assign dvs_mag = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);

	// one restoring step
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign ge      = ~trial[DATA_W];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dvd_mag;
			dvs_q     <= dvs_mag;
			neg_quo_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			neg_rem_q <= dividend[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
	end

	// apply signs
	assign quot = neg_quo_q ? -$signed(quo_q) : $signed(quo_q);
	assign rem  = neg_rem_q ? -$signed(rem_q) : $signed(rem_q);
	assign done = done_q;
endmodule

// ===== rtl/checked_stack_machine.sv =====
// Checked integer stack machine: top two entries in registers, the rest in RAM.
// Most instructions complete when accepted; POP or a binary op on a stack deeper
// than two entries adds a RAM refill of the second entry, MUL passes through ST_MUL,
// and DIV and MOD wait in ST_DIV for the serial divider, which is the slowest path.
// Input stalls outside ST_IDLE. FINISH loads the output register when accepted.
// Reset clears depth, error flag and control; stack RAM contents stay undefined.
module checked_stack_machine #(
	parameter int STACK_DEPTH = csm_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [3:0]                        cmd,
	input  logic signed [csm_pkg::DATA_W-1:0] operand,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [csm_pkg::DATA_W-1:0] result_value,
	output logic                              is_error
);
	import csm_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	state_t state_q, state_d;
	logic [DW-1:0]            depth_q;
	logic                     err_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] below_q;
	logic                     is_mod_q;
	logic signed [2*DATA_W-1:0] prod_s1;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic                     out_err_q;

	logic accept, active;
	logic under1, under2, full, deep3;
	logic op_big;
	logic signed [RES_W-1:0] res_w;
	logic res_big;
	logic commit_bin, commit_ok, pop_ok, need_refill;
	logic push_num, push_dup, push_ok, swap_ok, inv_ok;
	logic mul_go, div_go;
	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic signed [DATA_W-1:0] div_quot, div_rem;
	logic div_done;

	// handshake
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign active   = accept && !err_q;

	// stack conditions
	assign under1 = (depth_q == '0);
	assign under2 = (depth_q < DW'(2));
	assign full   = (depth_q == DW'(STACK_DEPTH));
	assign deep3  = (depth_q > DW'(2));
	assign op_big = too_big(RES_W'(operand));

	// binary result from whichever unit finishes
	always_comb begin
		unique case (state_q)
			ST_MUL:  res_w = RES_W'(prod_s1);
			ST_DIV:  res_w = RES_W'(is_mod_q ? div_rem : div_quot);
			default: res_w = (cmd == CMD_SUB) ? RES_W'(below_q) - RES_W'(top_q)
			                                  : RES_W'(below_q) + RES_W'(top_q);
		endcase
	end
	assign res_big = too_big(res_w);

	// instruction decisions
	assign push_num   = active && (cmd == CMD_NUM) && !op_big && !full;
	assign push_dup   = active && (cmd == CMD_DUP) && !under1 && !full;
	assign push_ok    = push_num || push_dup;
	assign swap_ok    = active && (cmd == CMD_SWP) && !under2;
	assign inv_ok     = active && (cmd == CMD_INV) && !under1;
	assign pop_ok     = active && (cmd == CMD_POP) && !under1;
	assign mul_go     = active && (cmd == CMD_MUL) && !under2;
	assign div_go     = active && ((cmd == CMD_DIV) || (cmd == CMD_MOD)) && !under2
	                    && (top_q != '0);
	assign commit_bin = (active && ((cmd == CMD_ADD) || (cmd == CMD_SUB)) && !under2)
	                    || (state_q == ST_MUL) || (state_q == ST_DIV && div_done);
	assign commit_ok  = commit_bin && !res_big;
	assign need_refill = (commit_ok || pop_ok) && deep3;

	// spill the second entry on push, refill it after a shrink
	assign wr_en   = push_ok && !under2;
	assign wr_addr = AW'(depth_q - DW'(2));
	assign rd_en   = need_refill;
	assign rd_addr = AW'(depth_q - DW'(3));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (mul_go) state_d = ST_MUL;
				else if (div_go) state_d = ST_DIV;
				else if (need_refill) state_d = ST_REFILL;
			end
			ST_MUL: state_d = need_refill ? ST_REFILL : ST_IDLE;
			ST_DIV: begin
				if (div_done) state_d = need_refill ? ST_REFILL : ST_IDLE;
			end
			ST_REFILL: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && cmd == CMD_FINISH) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (accept && cmd == CMD_START) begin
				err_q   <= op_big;
				depth_q <= op_big ? DW'(0) : DW'(1);
			end else if (push_ok) begin
				depth_q <= depth_q + DW'(1);
			end else if (pop_ok || commit_ok) begin
				depth_q <= depth_q - DW'(1);
			end else if (commit_bin && res_big) begin
				err_q <= 1'b1;
			end else if (active && cmd < CMD_FINISH && !mul_go && !div_go && !swap_ok
			             && !inv_ok && !commit_bin) begin
				// failed instruction: underflow, overflow, range or divide by zero
				err_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_FINISH) begin
			out_err_q   <= err_q || (depth_q != DW'(1));
			out_value_q <= (err_q || (depth_q != DW'(1))) ? '0 : top_q;
		end
		if (mul_go) prod_s1 <= below_q * top_q;
		if (div_go) is_mod_q <= (cmd == CMD_MOD);
		if (state_q == ST_REFILL) below_q <= $signed(rd_data);
		if (accept && cmd == CMD_START && !op_big) begin
			top_q <= operand;
		end else if (push_num) begin
			below_q <= top_q;
			top_q   <= operand;
		end else if (push_dup) begin
			below_q <= top_q;
		end else if (swap_ok) begin
			top_q   <= below_q;
			below_q <= top_q;
		end else if (inv_ok) begin
			top_q <= -top_q;
		end else if (pop_ok) begin
			top_q <= below_q;
		end else if (commit_ok) begin
			top_q <= res_w[DATA_W-1:0];
		end
	end

	csm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (below_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	csm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (below_q),
		.divisor  (top_q),
		.quot     (div_quot),
		.rem      (div_rem),
		.done     (div_done)
	);

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign is_error     = out_err_q;

	// checks
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");
	a_refill_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REFILL |-> $past(rd_en))
		else $error("refill without RAM read");
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept && cmd == CMD_FINISH))
		else $error("result beat without finish");
	a_err_keeps_depth: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(err_q) && !$past(accept && cmd == CMD_START) |-> $stable(depth_q))
		else $error("failed instruction changed depth");
endmodule
